@@ rtl/kjtb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the k-mer skip-table builder: sizes, codes, transaction structs,
// the front-to-back command type, the back-end state type and the span function.
// No dependencies.
package kjtb_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int QUEUE_DEPTH = 1024;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = QUEUE_AW + 1;
    localparam int MAX_JUMP    = 255;
    localparam int JUMP_W      = 8;
    localparam int IDX_W       = 16;
    localparam int CLASS_W     = 32;
    localparam int POS_W       = 30;
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_AW      = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    localparam logic FUNC_OCC  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [CLASS_W-1:0] NO_CLASS = '1;

    typedef struct packed {
        logic               func;
        logic [IDX_W-1:0]   kmer_index;
        logic [CLASS_W-1:0] eq_class;
        logic [POS_W-1:0]   position;
        logic               reverse_comp;
        logic               end_of_transcript;
    } t_in_item;

    typedef struct packed {
        logic [JUMP_W-1:0] fwd_jump;
        logic [JUMP_W-1:0] rev_jump;
        logic              status;
    } t_out_item;

    // One queued occurrence.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] pos;
        logic             rc;
    } t_cell;

    // Command handed from the front end to the back end.
    typedef struct packed {
        logic                func;
        logic [IDX_W-1:0]    kmer_index;
        logic [POS_W-1:0]    position;
        logic                reverse_comp;
        logic                status;
        logic                enq;
        logic [QUEUE_AW-1:0] enq_addr;
        logic [COUNT_W-1:0]  pre_n;
        logic [POS_W-1:0]    pre_lb;
        logic [COUNT_W-1:0]  eot_n;
        logic [POS_W-1:0]    eot_lb;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RDOUT,
        S_FQ,
        S_FT,
        S_FM,
        S_ENQ
    } t_back_state;

    typedef enum logic {
        PH_PRE,
        PH_EOT
    } t_phase;

    // Inclusive distance from lo to hi, zero when hi is below lo, capped at MAX_JUMP.
    function automatic logic [JUMP_W-1:0] span(input logic [POS_W-1:0] hi,
                                               input logic [POS_W-1:0] lo);
        logic [POS_W:0] d;
        d = {1'b0, hi} - {1'b0, lo};
        if (hi < lo) begin
            return '0;
        end else if (d >= (POS_W+1)'(MAX_JUMP)) begin
            return JUMP_W'(MAX_JUMP);
        end else begin
            return JUMP_W'(d[JUMP_W-1:0] + JUMP_W'(1));
        end
    endfunction

endpackage

@@ rtl/kjtb_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kjtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/kjtb_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts transactions, tracks class, break and queue fill,
// and turns each item into a command for the back end. Depends on kjtb_pkg.
module kjtb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  kjtb_pkg::t_in_item i_item,
    input  logic              i_fifo_full,
    input  logic              i_clearing,
    output logic              o_busy,
    output logic              o_push,
    output kjtb_pkg::t_cmd    o_cmd
);

    logic [kjtb_pkg::COUNT_W-1:0] r_count, n_count;
    logic [kjtb_pkg::POS_W-1:0]   r_last_break, n_last_break;
    logic [kjtb_pkg::CLASS_W-1:0] r_prev_class, n_prev_class;

    logic                         accept;
    logic                         chg;
    logic                         enq;
    logic [kjtb_pkg::COUNT_W-1:0] c1;
    logic [kjtb_pkg::COUNT_W-1:0] c2;
    logic [kjtb_pkg::POS_W-1:0]   lb1;

    assign o_busy = i_fifo_full || i_clearing;
    assign accept = i_start && !o_busy;
    assign o_push = accept;

    always_comb begin
        chg = (i_item.eq_class != r_prev_class);
        c1  = chg ? '0 : r_count;
        enq = (c1 < kjtb_pkg::COUNT_W'(kjtb_pkg::QUEUE_DEPTH));
        c2  = enq ? kjtb_pkg::COUNT_W'(c1 + kjtb_pkg::COUNT_W'(1)) : c1;
        lb1 = chg ? i_item.position : r_last_break;

        o_cmd.func         = i_item.func;
        o_cmd.kmer_index   = i_item.kmer_index;
        o_cmd.position     = i_item.position;
        o_cmd.reverse_comp = i_item.reverse_comp;
        o_cmd.status       = !enq;
        o_cmd.enq          = enq;
        o_cmd.enq_addr     = c1[kjtb_pkg::QUEUE_AW-1:0];
        o_cmd.pre_n        = chg ? r_count : '0;
        o_cmd.pre_lb       = r_last_break;
        o_cmd.eot_n        = i_item.end_of_transcript ? c2 : '0;
        o_cmd.eot_lb       = lb1;

        n_count      = r_count;
        n_last_break = r_last_break;
        n_prev_class = r_prev_class;
        if (accept && i_item.func == kjtb_pkg::FUNC_OCC) begin
            if (i_item.end_of_transcript) begin
                n_count      = '0;
                n_last_break = '0;
                n_prev_class = kjtb_pkg::NO_CLASS;
            end else begin
                n_count      = c2;
                n_last_break = lb1;
                n_prev_class = i_item.eq_class;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_last_break <= '0;
            r_prev_class <= kjtb_pkg::NO_CLASS;
        end else begin
            r_count      <= n_count;
            r_last_break <= n_last_break;
            r_prev_class <= n_prev_class;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kjtb_pkg::COUNT_W'(kjtb_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond queue depth");
`endif

endmodule

@@ rtl/kjtb_cmd_fifo.sv @@
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on kjtb_pkg.
module kjtb_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kjtb_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output kjtb_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);

    kjtb_pkg::t_cmd                 r_mem [kjtb_pkg::CMD_DEPTH];
    logic [kjtb_pkg::CMD_AW-1:0]    r_wp, n_wp;
    logic [kjtb_pkg::CMD_AW-1:0]    r_rp, n_rp;
    logic [kjtb_pkg::CMD_CNT_W-1:0] r_cnt, n_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == kjtb_pkg::CMD_CNT_W'(kjtb_pkg::CMD_DEPTH));

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == kjtb_pkg::CMD_AW'(kjtb_pkg::CMD_DEPTH - 1)) ? '0
                 : kjtb_pkg::CMD_AW'(r_wp + kjtb_pkg::CMD_AW'(1));
        end
        if (i_pop) begin
            n_rp = (r_rp == kjtb_pkg::CMD_AW'(kjtb_pkg::CMD_DEPTH - 1)) ? '0
                 : kjtb_pkg::CMD_AW'(r_rp + kjtb_pkg::CMD_AW'(1));
        end
        if (i_push && !i_pop) begin
            n_cnt = kjtb_pkg::CMD_CNT_W'(r_cnt + kjtb_pkg::CMD_CNT_W'(1));
        end else if (!i_push && i_pop) begin
            n_cnt = kjtb_pkg::CMD_CNT_W'(r_cnt - kjtb_pkg::CMD_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && o_empty))
        else $error("command queue pushed when full or popped when empty");
`endif

endmodule

@@ rtl/kjtb_back.sv @@
`timescale 1ns / 1ps
// Back end: clears the skip tables after reset, writes the occurrence queue,
// flushes queued cells into the tables and answers reads. Depends on kjtb_pkg, kjtb_ram.
module kjtb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kjtb_pkg::t_cmd      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_done,
    output kjtb_pkg::t_out_item o_result
);

    kjtb_pkg::t_back_state        r_state, n_state;
    kjtb_pkg::t_phase             r_phase, n_phase;
    logic [kjtb_pkg::COUNT_W-1:0] r_i, n_i;
    logic [kjtb_pkg::COUNT_W-1:0] r_n, n_n;
    logic [kjtb_pkg::TABLE_AW-1:0] r_clr_addr, n_clr_addr;
    logic                         r_done, n_done;

    kjtb_pkg::t_cmd               r_cmd, n_cmd;
    logic [kjtb_pkg::POS_W-1:0]   r_lb, n_lb;
    logic [kjtb_pkg::JUMP_W-1:0]  r_fv, n_fv;
    logic [kjtb_pkg::JUMP_W-1:0]  r_rv, n_rv;
    logic [kjtb_pkg::TABLE_AW-1:0] r_taddr, n_taddr;
    kjtb_pkg::t_out_item          r_result, n_result;

    logic                          q_we;
    logic [kjtb_pkg::QUEUE_AW-1:0] q_raddr;
    kjtb_pkg::t_cell               q_wdata;
    logic [$bits(kjtb_pkg::t_cell)-1:0] q_rdata;
    kjtb_pkg::t_cell               q_cell;

    logic                          t_we;
    logic [kjtb_pkg::TABLE_AW-1:0] t_waddr;
    logic [kjtb_pkg::TABLE_AW-1:0] t_raddr;
    logic [kjtb_pkg::JUMP_W-1:0]   fwd_wdata, rev_wdata;
    logic [kjtb_pkg::JUMP_W-1:0]   fwd_rdata, rev_rdata;
    logic [kjtb_pkg::JUMP_W-1:0]   span_at, span_lb;

    assign q_cell = kjtb_pkg::t_cell'(q_rdata);

    kjtb_ram #(.WIDTH($bits(kjtb_pkg::t_cell)), .DEPTH(kjtb_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(r_cmd.enq_addr),
        .i_wdata(q_wdata),
        .i_raddr(q_raddr),
        .o_rdata(q_rdata)
    );

    kjtb_ram #(.WIDTH(kjtb_pkg::JUMP_W), .DEPTH(kjtb_pkg::TABLE_DEPTH)) u_fwd_table (
        .i_clk  (i_clk),
        .i_we   (t_we),
        .i_waddr(t_waddr),
        .i_wdata(fwd_wdata),
        .i_raddr(t_raddr),
        .o_rdata(fwd_rdata)
    );

    kjtb_ram #(.WIDTH(kjtb_pkg::JUMP_W), .DEPTH(kjtb_pkg::TABLE_DEPTH)) u_rev_table (
        .i_clk  (i_clk),
        .i_we   (t_we),
        .i_waddr(t_waddr),
        .i_wdata(rev_wdata),
        .i_raddr(t_raddr),
        .o_rdata(rev_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            kjtb_pkg::S_CLR: begin
                if (r_clr_addr == kjtb_pkg::TABLE_AW'(kjtb_pkg::TABLE_DEPTH - 1)) begin
                    n_state = kjtb_pkg::S_IDLE;
                end
            end
            kjtb_pkg::S_IDLE: begin
                if (!i_empty) begin
                    if (i_head.func == kjtb_pkg::FUNC_READ) begin
                        n_state = kjtb_pkg::S_RDOUT;
                    end else if (i_head.pre_n != '0) begin
                        n_state = kjtb_pkg::S_FQ;
                    end else begin
                        n_state = kjtb_pkg::S_ENQ;
                    end
                end
            end
            kjtb_pkg::S_RDOUT: n_state = kjtb_pkg::S_IDLE;
            kjtb_pkg::S_FQ: begin
                if (r_i == r_n) begin
                    n_state = (r_phase == kjtb_pkg::PH_PRE) ? kjtb_pkg::S_ENQ
                                                           : kjtb_pkg::S_IDLE;
                end else begin
                    n_state = kjtb_pkg::S_FT;
                end
            end
            kjtb_pkg::S_FT: n_state = kjtb_pkg::S_FM;
            kjtb_pkg::S_FM: n_state = kjtb_pkg::S_FQ;
            kjtb_pkg::S_ENQ: begin
                n_state = (r_cmd.eot_n != '0) ? kjtb_pkg::S_FQ : kjtb_pkg::S_IDLE;
            end
            default: n_state = kjtb_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        span_at = kjtb_pkg::span(r_cmd.position, q_cell.pos);
        span_lb = kjtb_pkg::span(q_cell.pos, r_lb);

        n_phase    = r_phase;
        n_i        = r_i;
        n_n        = r_n;
        n_clr_addr = r_clr_addr;
        n_done     = 1'b0;
        n_cmd      = r_cmd;
        n_lb       = r_lb;
        n_fv       = r_fv;
        n_rv       = r_rv;
        n_taddr    = r_taddr;
        n_result   = r_result;

        o_pop     = 1'b0;
        q_we      = 1'b0;
        q_raddr   = r_i[kjtb_pkg::QUEUE_AW-1:0];
        q_wdata   = '{idx: r_cmd.kmer_index, pos: r_cmd.position, rc: r_cmd.reverse_comp};
        t_we      = 1'b0;
        t_waddr   = r_taddr;
        t_raddr   = q_cell.idx;
        fwd_wdata = (r_fv < fwd_rdata) ? r_fv : fwd_rdata;
        rev_wdata = (r_rv < rev_rdata) ? r_rv : rev_rdata;

        case (r_state)
            kjtb_pkg::S_CLR: begin
                t_we       = 1'b1;
                t_waddr    = r_clr_addr;
                fwd_wdata  = kjtb_pkg::JUMP_W'(kjtb_pkg::MAX_JUMP);
                rev_wdata  = kjtb_pkg::JUMP_W'(kjtb_pkg::MAX_JUMP);
                n_clr_addr = kjtb_pkg::TABLE_AW'(r_clr_addr + kjtb_pkg::TABLE_AW'(1));
            end
            kjtb_pkg::S_IDLE: begin
                t_raddr = i_head.kmer_index;
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head;
                    n_i     = '0;
                    n_n     = i_head.pre_n;
                    n_lb    = i_head.pre_lb;
                    n_phase = kjtb_pkg::PH_PRE;
                end
            end
            kjtb_pkg::S_RDOUT: begin
                n_done   = 1'b1;
                n_result = '{fwd_jump: fwd_rdata, rev_jump: rev_rdata, status: 1'b0};
            end
            kjtb_pkg::S_FQ: begin
                if (r_i == r_n && r_phase == kjtb_pkg::PH_EOT) begin
                    n_done   = 1'b1;
                    n_result = '{fwd_jump: '0, rev_jump: '0, status: r_cmd.status};
                end
            end
            kjtb_pkg::S_FT: begin
                // Reverse-complement cells swap which table each distance feeds.
                n_taddr = q_cell.idx;
                n_fv    = q_cell.rc ? span_lb : span_at;
                n_rv    = q_cell.rc ? span_at : span_lb;
            end
            kjtb_pkg::S_FM: begin
                t_we = 1'b1;
                n_i  = kjtb_pkg::COUNT_W'(r_i + kjtb_pkg::COUNT_W'(1));
            end
            kjtb_pkg::S_ENQ: begin
                q_we    = r_cmd.enq;
                n_i     = '0;
                n_n     = r_cmd.eot_n;
                n_lb    = r_cmd.eot_lb;
                n_phase = kjtb_pkg::PH_EOT;
                if (r_cmd.eot_n == '0) begin
                    n_done   = 1'b1;
                    n_result = '{fwd_jump: '0, rev_jump: '0, status: r_cmd.status};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kjtb_pkg::S_CLR;
            r_phase    <= kjtb_pkg::PH_PRE;
            r_i        <= '0;
            r_n        <= '0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_i        <= n_i;
            r_n        <= n_n;
            r_clr_addr <= n_clr_addr;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_lb     <= n_lb;
        r_fv     <= n_fv;
        r_rv     <= n_rv;
        r_taddr  <= n_taddr;
        r_result <= n_result;
    end

    assign o_clearing = (r_state == kjtb_pkg::S_CLR);
    assign o_done     = r_done;
    assign o_result   = r_result;

`ifndef SYNTHESIS
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == kjtb_pkg::S_RDOUT || $past(r_state) == kjtb_pkg::S_ENQ
                    || $past(r_state) == kjtb_pkg::S_FQ))
        else $error("result strobe without a finishing state");
    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kjtb_pkg::S_FT || r_state == kjtb_pkg::S_FM) |-> r_i < r_n)
        else $error("flush index ran past the queued cell count");
    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clearing |-> !o_pop && !o_done)
        else $error("command taken while tables are being cleared");
`endif

endmodule

@@ rtl/kjtb_top_unused_guard.sv @@
`timescale 1ns / 1ps
// Result-strobe checker on the top-level ports of the skip-table builder.
// Depends on kjtb_pkg.
module kjtb_top_unused_guard (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic                i_done,
    input  kjtb_pkg::t_out_item i_result
);

    logic [kjtb_pkg::COUNT_W:0] r_outstanding, n_outstanding;

    // Counts accepted transactions whose result has not yet been strobed.
    always_comb begin
        n_outstanding = r_outstanding;
        if ((i_start && !i_busy) && !i_done) begin
            n_outstanding = (kjtb_pkg::COUNT_W+1)'(r_outstanding + 1'b1);
        end else if (!(i_start && !i_busy) && i_done) begin
            n_outstanding = (kjtb_pkg::COUNT_W+1)'(r_outstanding - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

`ifndef SYNTHESIS
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> r_outstanding != '0)
        else $error("result strobe with no transaction outstanding");
    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_done && i_result.status) |-> (i_result.fwd_jump == '0 && i_result.rev_jump == '0))
        else $error("dropped occurrence reported with table data");
`endif

endmodule

@@ rtl/kmer_jump_table_builder.sv @@
`timescale 1ns / 1ps
// Top level of the k-mer skip-table builder: front end, command queue, back end.
// Depends on kjtb_pkg, kjtb_front, kjtb_cmd_fifo, kjtb_back, kjtb_top_unused_guard.
//
//  Channel   Ports                      Transfer rule
//  --------  -------------------------  ---------------------------------------
//  input     start, busy, i_item        taken at a rising edge with start && !busy
//  result    o_done, o_result           one-cycle strobe, taken at the next edge
//
// After reset busy stays high while both tables are swept to 255. A read passes the idle
// and read-out states, an occurrence without a flush the idle and enqueue states; each
// flush, on a class change or a transcript end, adds a check state plus a queue read,
// table read and table write per queued cell. The registered result strobe comes in the
// cycle after that work ends. The front end keeps taking transactions until the two-entry
// command queue fills, and busy shows that. The receiver cannot stall.
module kmer_jump_table_builder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  kjtb_pkg::t_in_item  i_item,
    output logic                o_done,
    output kjtb_pkg::t_out_item o_result
);

    // Command transactions between the front and back ends.
    logic           push;
    logic           pop;
    logic           fifo_empty;
    logic           fifo_full;
    logic           clearing;
    kjtb_pkg::t_cmd push_cmd;
    kjtb_pkg::t_cmd head_cmd;

    // The front end owns all sequence-dependent bookkeeping (class, break, fill count),
    // so every command reaching the back end is already fully classified.
    kjtb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (i_item),
        .i_fifo_full(fifo_full),
        .i_clearing (clearing),
        .o_busy     (busy),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    kjtb_cmd_fifo u_cmd_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_head (head_cmd),
        .o_empty(fifo_empty),
        .o_full (fifo_full)
    );

    // The back end holds the occurrence queue and both skip tables and emits every result in command order.
    kjtb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head_cmd),
        .i_empty   (fifo_empty),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    kjtb_top_unused_guard u_port_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_busy  (busy),
        .i_done  (o_done),
        .i_result(o_result)
    );

endmodule
